// ===== hdl/slu4_pkg.sv =====
// ----------------------------------------------------------------------------
// slu4_pkg
// Shared types, codes and reset values for the four-channel serial line unit.
// ----------------------------------------------------------------------------
package slu4_pkg;

    localparam int SLU_CHANNELS = 4;
    localparam int CH_EXT_W     = 5;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_POLL  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SEL_RX_CSR = 2'd0,
        SEL_RX_BUF = 2'd1,
        SEL_TX_CSR = 2'd2,
        SEL_TX_BUF = 2'd3
    } sel_t;

    localparam logic [1:0] CFG_LF_BREAK    = 2'd0;
    localparam logic [1:0] CFG_VECTOR_BASE = 2'd1;
    localparam logic [1:0] CFG_TX_DELAY    = 2'd2;

    localparam logic [8:0] VECTOR_BASE_RST = 9'd48;
    localparam logic [7:0] TX_DELAY_RST    = 8'd32;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam int CSR_DONE_BIT = 7;
    localparam int CSR_IE_BIT   = 6;

endpackage

// ===== hdl/slu4_if.sv =====
// ----------------------------------------------------------------------------
// slu4 channel interfaces
// Command and response channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface slu4_cmd_if;
    import slu4_pkg::*;

    logic       valid;
    logic       ready;
    op_t        op;
    logic [1:0] channel;
    sel_t       reg_select;
    logic [15:0] write_data;
    logic       rx_present;
    logic [7:0] rx_char;

    modport source (output valid, op, channel, reg_select, write_data, rx_present, rx_char,
                    input ready);
    modport sink   (input valid, op, channel, reg_select, write_data, rx_present, rx_char,
                    output ready);
endinterface

interface slu4_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       rx_irq;
    logic [9:0] rx_vector;
    logic       tx_irq;
    logic [9:0] tx_vector;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic       break_request;

    modport source (output valid, read_data, rx_irq, rx_vector, tx_irq, tx_vector,
                    tx_valid, tx_char, break_request,
                    input ready);
    modport sink   (input valid, read_data, rx_irq, rx_vector, tx_irq, tx_vector,
                    tx_valid, tx_char, break_request,
                    output ready);
endinterface

// ===== hdl/serial_line_unit_4ch_core.sv =====
// ----------------------------------------------------------------------------
// serial_line_unit_4ch_core
// Multi-channel serial line unit: register access, poll ticks, channel clear.
//
// Each command beat is registered, processed against the addressed channel's
// state, and its single response beat is registered on the way out. One beat
// per cycle is sustained while the response side is ready. A command beat
// passes the command stage register and then the response stage register, and
// a response that is not taken holds the command stage. While a response waits,
// the command side takes one more beat into the empty middle stage and then
// stalls until the response is taken. Configuration (lf_break_enable,
// vector_base, tx_delay) is written over the APB port at byte addresses 0, 4 and
// 8 while the unit is idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module serial_line_unit_4ch_core #(
    parameter int CHANNELS = slu4_pkg::SLU_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    slu4_cmd_if.sink    cmd,
    slu4_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slu4_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_EXT_W-1:0] CH_LIMIT = CH_EXT_W'(CHANNELS);

    // configuration
    logic       lf_break_reg;
    logic [8:0] vector_base_reg;
    logic [7:0] tx_delay_reg;
    logic       cfg_wr;

    // per-channel state
    logic       rx_done_reg  [CHANNELS];
    logic       rx_ie_reg    [CHANNELS];
    logic [6:0] rx_buf_reg   [CHANNELS];
    logic       tx_ready_reg [CHANNELS];
    logic       tx_ie_reg    [CHANNELS];
    logic [7:0] tx_buf_reg   [CHANNELS];
    logic [7:0] tx_wait_reg  [CHANNELS];

    // command stage
    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [1:0]  s1_ch_reg;
    sel_t        s1_sel_reg;
    logic [15:0] s1_wd_reg;
    logic        s1_present_reg;
    logic [7:0]  s1_char_reg;

    // response stage
    logic       res_valid_reg;
    logic       res_valid_next;
    logic [7:0] res_rd_reg,   res_rd_next;
    logic       res_rxi_reg,  res_rxi_next;
    logic [9:0] res_rxv_reg,  res_rxv_next;
    logic       res_txi_reg,  res_txi_next;
    logic [9:0] res_txv_reg,  res_txv_next;
    logic       res_txv_valid_reg, res_txv_valid_next;
    logic [6:0] res_txc_reg,  res_txc_next;
    logic       res_brk_reg,  res_brk_next;

    logic                advance;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    logic [CH_EXT_W-1:0] ch_ext;
    logic [9:0]          vec_rx;

    // selected channel, current and next
    logic       cur_rx_done, cur_rx_ie, cur_tx_ready, cur_tx_ie;
    logic [6:0] cur_rx_buf;
    logic [7:0] cur_tx_buf, cur_tx_wait;
    logic       rx_done_next, rx_ie_next, tx_ready_next, tx_ie_next;
    logic [6:0] rx_buf_next;
    logic [7:0] tx_buf_next, tx_wait_next;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lf_break_reg    <= 1'b0;
            vector_base_reg <= VECTOR_BASE_RST;
            tx_delay_reg    <= TX_DELAY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                CFG_LF_BREAK:    lf_break_reg    <= pwdata[0];
                CFG_VECTOR_BASE: vector_base_reg <= pwdata[8:0];
                CFG_TX_DELAY:    tx_delay_reg    <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_LF_BREAK:    prdata = {31'd0, lf_break_reg};
            CFG_VECTOR_BASE: prdata = {23'd0, vector_base_reg};
            CFG_TX_DELAY:    prdata = {24'd0, tx_delay_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance   = s1_valid_reg & (~res_valid_reg | res.ready);
    assign cmd.ready = ~s1_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd.ready)
            s1_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_op_reg      <= cmd.op;
            s1_ch_reg      <= cmd.channel;
            s1_sel_reg     <= cmd.reg_select;
            s1_wd_reg      <= cmd.write_data;
            s1_present_reg <= cmd.rx_present;
            s1_char_reg    <= cmd.rx_char;
        end
    end

    // ---------------- processing ----------------
    assign ch_ext   = {{(CH_EXT_W-2){1'b0}}, s1_ch_reg};
    assign in_range = ch_ext < CH_LIMIT;
    assign idx      = ch_ext[IDX_W-1:0];
    assign vec_rx   = {1'b0, vector_base_reg} + {5'd0, s1_ch_reg, 3'd0};

    assign cur_rx_done  = rx_done_reg[idx];
    assign cur_rx_ie    = rx_ie_reg[idx];
    assign cur_rx_buf   = rx_buf_reg[idx];
    assign cur_tx_ready = tx_ready_reg[idx];
    assign cur_tx_ie    = tx_ie_reg[idx];
    assign cur_tx_buf   = tx_buf_reg[idx];
    assign cur_tx_wait  = tx_wait_reg[idx];

    always_comb
    begin
        rx_done_next       = cur_rx_done;
        rx_ie_next         = cur_rx_ie;
        rx_buf_next        = cur_rx_buf;
        tx_ready_next      = cur_tx_ready;
        tx_ie_next         = cur_tx_ie;
        tx_buf_next        = cur_tx_buf;
        tx_wait_next       = cur_tx_wait;
        res_rd_next        = 8'd0;
        res_rxi_next       = 1'b0;
        res_rxv_next       = 10'd0;
        res_txi_next       = 1'b0;
        res_txv_next       = 10'd0;
        res_txv_valid_next = 1'b0;
        res_txc_next       = 7'd0;
        res_brk_next       = 1'b0;

        if (in_range)
        begin
            unique case (s1_op_reg)
                OP_READ:
                begin
                    unique case (s1_sel_reg)
                        SEL_RX_CSR: res_rd_next = {cur_rx_done, cur_rx_ie, 6'd0};
                        SEL_RX_BUF:
                        begin
                            if (cur_rx_done)
                            begin
                                res_rd_next  = {1'b0, cur_rx_buf};
                                rx_done_next = 1'b0;
                            end
                        end
                        SEL_TX_CSR: res_rd_next = {cur_tx_ready, cur_tx_ie, 6'd0};
                        default:    res_rd_next = 8'd0;
                    endcase
                end
                OP_WRITE:
                begin
                    unique case (s1_sel_reg)
                        SEL_RX_CSR: rx_ie_next = s1_wd_reg[CSR_IE_BIT];
                        SEL_TX_CSR: tx_ie_next = s1_wd_reg[CSR_IE_BIT];
                        SEL_TX_BUF:
                        begin
                            tx_buf_next   = s1_wd_reg[7:0];
                            tx_ready_next = 1'b0;
                            tx_wait_next  = 8'd0;
                        end
                        default: ;
                    endcase
                end
                OP_POLL:
                begin
                    if (s1_present_reg)
                    begin
                        res_brk_next = lf_break_reg &
                                       (s1_char_reg == CHAR_LF || s1_char_reg == CHAR_CR);
                        rx_buf_next  = s1_char_reg[6:0];
                        rx_done_next = 1'b1;
                        if (cur_rx_ie)
                        begin
                            res_rxi_next = 1'b1;
                            res_rxv_next = vec_rx;
                        end
                    end
                    if (!cur_tx_ready)
                    begin
                        if (cur_tx_wait >= tx_delay_reg)
                        begin
                            res_txv_valid_next = 1'b1;
                            res_txc_next       = cur_tx_buf[6:0];
                            tx_ready_next      = 1'b1;
                            if (cur_tx_ie)
                            begin
                                res_txi_next = 1'b1;
                                res_txv_next = vec_rx + 10'd4;
                            end
                        end
                        else
                            tx_wait_next = cur_tx_wait + 8'd1;
                    end
                end
                OP_CLEAR:
                begin
                    rx_done_next  = 1'b0;
                    rx_ie_next    = 1'b0;
                    rx_buf_next   = 7'd0;
                    tx_ready_next = 1'b1;
                    tx_ie_next    = 1'b0;
                    tx_buf_next   = 8'd0;
                    tx_wait_next  = 8'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                rx_done_reg[i]  <= 1'b0;
                rx_ie_reg[i]    <= 1'b0;
                rx_buf_reg[i]   <= 7'd0;
                tx_ready_reg[i] <= 1'b1;
                tx_ie_reg[i]    <= 1'b0;
                tx_buf_reg[i]   <= 8'd0;
                tx_wait_reg[i]  <= 8'd0;
            end
        end
        else if (advance && in_range)
        begin
            rx_done_reg[idx]  <= rx_done_next;
            rx_ie_reg[idx]    <= rx_ie_next;
            rx_buf_reg[idx]   <= rx_buf_next;
            tx_ready_reg[idx] <= tx_ready_next;
            tx_ie_reg[idx]    <= tx_ie_next;
            tx_buf_reg[idx]   <= tx_buf_next;
            tx_wait_reg[idx]  <= tx_wait_next;
        end
    end

    // ---------------- response stage ----------------
    assign res_valid_next = advance | (res_valid_reg & ~res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_rd_reg        <= res_rd_next;
            res_rxi_reg       <= res_rxi_next;
            res_rxv_reg       <= res_rxv_next;
            res_txi_reg       <= res_txi_next;
            res_txv_reg       <= res_txv_next;
            res_txv_valid_reg <= res_txv_valid_next;
            res_txc_reg       <= res_txc_next;
            res_brk_reg       <= res_brk_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.read_data     = res_rd_reg;
    assign res.rx_irq        = res_rxi_reg;
    assign res.rx_vector     = res_rxv_reg;
    assign res.tx_irq        = res_txi_reg;
    assign res.tx_vector     = res_txv_reg;
    assign res.tx_valid      = res_txv_valid_reg;
    assign res.tx_char       = res_txc_reg;
    assign res.break_request = res_brk_reg;

`ifndef SYNTHESIS
    // a held command beat is not dropped while the response side stalls
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && !res.ready |=> s1_valid_reg)
        else $error("command stage lost a beat under stall");

    // a transmit interrupt only accompanies a sent character
    a_txirq_char: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_txi_reg |-> res_txv_valid_reg)
        else $error("tx interrupt without transmitted character");

    // a response beat always follows a processed command beat
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("processed beat produced no response");
`endif

endmodule

// ===== test/tb_serial_line_unit_4ch_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_line_unit_4ch_core
// Self-checking bench for the four-channel serial line unit. A shadow of the
// per-channel registers predicts each response beat from every accepted
// command beat; responses are compared field by field in order. Directed
// register, poll and clear sequences come first, then random traffic under
// several configurations with varying sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------

import slu4_pkg::*;

typedef struct packed {
    op_t         op;
    logic [1:0]  channel;
    sel_t        reg_select;
    logic [15:0] write_data;
    logic        rx_present;
    logic [7:0]  rx_char;
} line_cmd_t;

typedef struct packed {
    logic [7:0] read_data;
    logic       rx_irq;
    logic [9:0] rx_vector;
    logic       tx_irq;
    logic [9:0] tx_vector;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic       break_request;
} line_res_t;

class line_unit_shadow;
    logic       lf_break;
    logic [8:0] vec_base;
    logic [7:0] tx_delay;
    logic       rx_done  [SLU_CHANNELS];
    logic       rx_ie    [SLU_CHANNELS];
    logic [6:0] rx_buf   [SLU_CHANNELS];
    logic       tx_ready [SLU_CHANNELS];
    logic       tx_ie    [SLU_CHANNELS];
    logic [7:0] tx_buf   [SLU_CHANNELS];
    logic [7:0] tx_wait  [SLU_CHANNELS];
    line_res_t  pending_responses [$];
    int errors;
    int commands;
    int responses;
    int chars_sent;
    int chars_read;
    int rx_irqs;
    int tx_irqs;
    int breaks;

    function new();
        lf_break = 1'b0;
        vec_base = VECTOR_BASE_RST;
        tx_delay = TX_DELAY_RST;
        for (int i = 0; i < SLU_CHANNELS; i++)
            clear_channel(i);
    endfunction

    function void clear_channel(int ch);
        rx_done[ch]  = 1'b0;
        rx_ie[ch]    = 1'b0;
        rx_buf[ch]   = '0;
        tx_ready[ch] = 1'b1;
        tx_ie[ch]    = 1'b0;
        tx_buf[ch]   = '0;
        tx_wait[ch]  = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            CFG_LF_BREAK:    lf_break = value[0];
            CFG_VECTOR_BASE: vec_base = value[8:0];
            CFG_TX_DELAY:    tx_delay = value[7:0];
            default: ;
        endcase
    endfunction

    function void note_command(line_cmd_t c);
        line_res_t  r;
        int         ch;
        logic [9:0] base;
        r = '0;
        ch = c.channel;
        base = {1'b0, vec_base} + {5'b0, c.channel, 3'b000};
        commands++;
        case (c.op)
            OP_READ:
                case (c.reg_select)
                    SEL_RX_CSR:
                        r.read_data = (8'(rx_done[ch]) << CSR_DONE_BIT)
                                    | (8'(rx_ie[ch]) << CSR_IE_BIT);
                    SEL_RX_BUF:
                        if (rx_done[ch])
                        begin
                            rx_done[ch] = 1'b0;
                            r.read_data = {1'b0, rx_buf[ch]};
                            chars_read++;
                        end
                    SEL_TX_CSR:
                        r.read_data = (8'(tx_ready[ch]) << CSR_DONE_BIT)
                                    | (8'(tx_ie[ch]) << CSR_IE_BIT);
                    default: ;
                endcase
            OP_WRITE:
                case (c.reg_select)
                    SEL_RX_CSR: rx_ie[ch] = c.write_data[CSR_IE_BIT];
                    SEL_TX_CSR: tx_ie[ch] = c.write_data[CSR_IE_BIT];
                    SEL_TX_BUF:
                    begin
                        tx_buf[ch]   = c.write_data[7:0];
                        tx_ready[ch] = 1'b0;
                        tx_wait[ch]  = '0;
                    end
                    default: ;
                endcase
            OP_POLL:
            begin
                if (c.rx_present)
                begin
                    if (lf_break && (c.rx_char == CHAR_LF || c.rx_char == CHAR_CR))
                    begin
                        r.break_request = 1'b1;
                        breaks++;
                    end
                    rx_buf[ch]  = c.rx_char[6:0];
                    rx_done[ch] = 1'b1;
                    if (rx_ie[ch])
                    begin
                        r.rx_irq    = 1'b1;
                        r.rx_vector = base;
                        rx_irqs++;
                    end
                end
                if (!tx_ready[ch])
                begin
                    if (tx_wait[ch] >= tx_delay)
                    begin
                        r.tx_valid   = 1'b1;
                        r.tx_char    = tx_buf[ch][6:0];
                        tx_ready[ch] = 1'b1;
                        chars_sent++;
                        if (tx_ie[ch])
                        begin
                            r.tx_irq    = 1'b1;
                            r.tx_vector = base + 10'd4;
                            tx_irqs++;
                        end
                    end
                    else
                        tx_wait[ch] = tx_wait[ch] + 8'd1;
                end
            end
            OP_CLEAR: clear_channel(ch);
            default: ;
        endcase
        pending_responses.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [9:0] got, logic [9:0] want);
        if (got !== want)
            report($sformatf("beat %0d %s got %0h want %0h", responses, name, got, want));
    endtask

    task check_response(line_res_t got);
        line_res_t want;
        if (pending_responses.size() == 0)
        begin
            report("response beat with nothing outstanding");
            return;
        end
        want = pending_responses.pop_front();
        check_field("read_data", 10'(got.read_data), 10'(want.read_data));
        check_field("rx_irq", 10'(got.rx_irq), 10'(want.rx_irq));
        check_field("rx_vector", got.rx_vector, want.rx_vector);
        check_field("tx_irq", 10'(got.tx_irq), 10'(want.tx_irq));
        check_field("tx_vector", got.tx_vector, want.tx_vector);
        check_field("tx_valid", 10'(got.tx_valid), 10'(want.tx_valid));
        check_field("tx_char", 10'(got.tx_char), 10'(want.tx_char));
        check_field("break_request", 10'(got.break_request), 10'(want.break_request));
        responses++;
    endtask
endclass

module tb_serial_line_unit_4ch_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 48;
    localparam int PHASE_ITEMS    = 32;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic hold_req = 1'b0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;

    line_unit_shadow shadow;

    slu4_cmd_if cmd_ch();
    slu4_res_if res_ch();

    serial_line_unit_4ch_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic line_cmd_t cmd_of(op_t op, logic [1:0] ch, sel_t sel,
                                         logic [15:0] wd, logic pres, logic [7:0] rc);
        line_cmd_t c;
        c.op         = op;
        c.channel    = ch;
        c.reg_select = sel;
        c.write_data = wd;
        c.rx_present = pres;
        c.rx_char    = rc;
        return c;
    endfunction

    function automatic line_cmd_t random_command();
        line_cmd_t  c;
        int         pick;
        logic [7:0] specials [4];
        specials = '{CHAR_LF, CHAR_CR, 8'h8A, 8'h8D};
        pick = $urandom_range(99);
        if (pick < 28)
            c.op = OP_READ;
        else if (pick < 58)
            c.op = OP_WRITE;
        else if (pick < 95)
            c.op = OP_POLL;
        else
            c.op = OP_CLEAR;
        c.channel    = 2'($urandom_range(3));
        c.reg_select = sel_t'($urandom_range(3));
        c.write_data = 16'($urandom_range(65535));
        c.rx_present = 1'($urandom_range(1));
        c.rx_char    = ($urandom_range(3) == 0) ? specials[$urandom_range(3)]
                                                : 8'($urandom_range(255));
        return c;
    endfunction

    task automatic send_command(input line_cmd_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= c.op;
        cmd_ch.channel    <= c.channel;
        cmd_ch.reg_select <= c.reg_select;
        cmd_ch.write_data <= c.write_data;
        cmd_ch.rx_present <= c.rx_present;
        cmd_ch.rx_char    <= c.rx_char;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        shadow.note_command(c);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (shadow.pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        shadow.set_register(idx, value);
    endtask

    task automatic configure(input logic lf, input logic [8:0] vb, input logic [7:0] dly);
        write_register(CFG_LF_BREAK, {31'b0, lf});
        write_register(CFG_VECTOR_BASE, {23'b0, vb});
        write_register(CFG_TX_DELAY, {24'b0, dly});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver back-pressure, with a long hold on request
    initial
    begin
        logic hold_ack;
        int   hold_left;
        hold_ack  = 1'b0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        line_res_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.read_data     = res_ch.read_data;
                got.rx_irq        = res_ch.rx_irq;
                got.rx_vector     = res_ch.rx_vector;
                got.tx_irq        = res_ch.tx_irq;
                got.tx_vector     = res_ch.tx_vector;
                got.tx_valid      = res_ch.tx_valid;
                got.tx_char       = res_ch.tx_char;
                got.break_request = res_ch.break_request;
                shadow.check_response(got);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles without a beat", quiet);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [8:0] phase_base  [6];
        logic [7:0] phase_delay [6];
        logic       phase_lf    [6];
        phase_base  = '{9'd48, 9'd511, 9'd0, 9'd300, 9'd128, 9'd0};
        phase_delay = '{8'd0, 8'd1, 8'd3, 8'd2, 8'd0, 8'd0};
        phase_lf    = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        shadow = new();

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.op         <= OP_READ;
        cmd_ch.channel    <= '0;
        cmd_ch.reg_select <= SEL_RX_CSR;
        cmd_ch.write_data <= '0;
        cmd_ch.rx_present <= 1'b0;
        cmd_ch.rx_char    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then register access, receive and transmit paths
        send_command(cmd_of(OP_READ, 2'd0, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd0, SEL_TX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_POLL, 2'd1, SEL_RX_CSR, 16'h0000, 1'b1, CHAR_LF));
        drain();
        configure(1'b1, 9'd0, 8'd2);
        send_command(cmd_of(OP_READ, 2'd0, SEL_RX_BUF, 16'hFFFF, 1'b1, 8'hFF));
        send_command(cmd_of(OP_READ, 2'd0, SEL_TX_BUF, 16'hFFFF, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd0, SEL_RX_CSR, 16'hFFFF, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd0, SEL_TX_CSR, 16'h0040, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd0, SEL_RX_BUF, 16'hFFFF, 1'b0, 8'h00));
        send_command(cmd_of(OP_POLL, 2'd0, SEL_RX_CSR, 16'h0000, 1'b1, CHAR_LF));
        send_command(cmd_of(OP_POLL, 2'd0, SEL_RX_CSR, 16'h0000, 1'b1, CHAR_CR));
        send_command(cmd_of(OP_POLL, 2'd0, SEL_RX_CSR, 16'h0000, 1'b1, 8'h8A));
        send_command(cmd_of(OP_READ, 2'd0, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd0, SEL_RX_BUF, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd0, SEL_RX_BUF, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd0, SEL_TX_BUF, 16'hFFFF, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd0, SEL_TX_CSR, 16'h0000, 1'b0, 8'h00));
        repeat (3)
            send_command(cmd_of(OP_POLL, 2'd0, SEL_TX_BUF, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd0, SEL_TX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd3, SEL_RX_CSR, 16'h0040, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd3, SEL_TX_BUF, 16'h00A5, 1'b0, 8'h00));
        send_command(cmd_of(OP_POLL, 2'd3, SEL_RX_CSR, 16'h0000, 1'b1, 8'hFF));
        send_command(cmd_of(OP_CLEAR, 2'd3, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd3, SEL_TX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd3, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_POLL, 2'd3, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        drain();

        // longest transmit delay, run out in full
        configure(1'b0, 9'd511, 8'd255);
        send_command(cmd_of(OP_WRITE, 2'd1, SEL_TX_CSR, 16'hFFFF, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd1, SEL_RX_CSR, 16'h0040, 1'b0, 8'h00));
        send_command(cmd_of(OP_WRITE, 2'd1, SEL_TX_BUF, 16'h00D5, 1'b0, 8'h00));
        repeat (257)
            send_command(cmd_of(OP_POLL, 2'd1, SEL_RX_CSR, 16'h0000, 1'($urandom_range(1)),
                                8'($urandom_range(255))));
        // delay lowered while a character is counting
        send_command(cmd_of(OP_WRITE, 2'd2, SEL_TX_BUF, 16'h00C3, 1'b0, 8'h00));
        repeat (4)
            send_command(cmd_of(OP_POLL, 2'd2, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        drain();
        configure(1'b0, 9'd511, 8'd0);
        send_command(cmd_of(OP_POLL, 2'd2, SEL_RX_CSR, 16'h0000, 1'b0, 8'h00));
        send_command(cmd_of(OP_READ, 2'd2, SEL_TX_CSR, 16'h0000, 1'b0, 8'h00));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:       begin snd_idle_pct = 10; rcv_idle_pct = 81; end
                1:       begin snd_idle_pct = 81; rcv_idle_pct = 10; end
                default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            endcase
            if (ph == 5)
                configure(1'($urandom_range(1)), 9'($urandom_range(511)),
                          8'($urandom_range(5)));
            else
                configure(phase_lf[ph], phase_base[ph], phase_delay[ph]);
            if (ph == 4)
            begin
                hold_req <= ~hold_req;
                repeat (16)
                    send_command(random_command());
            end
            repeat (PHASE_ITEMS)
                send_command(random_command());
            drain();
        end

        rcv_idle_pct = 0;
        repeat (8) @(posedge clk);
        if (shadow.pending_responses.size() != 0)
            shadow.report("responses still outstanding at end of run");
        $display("run: %0d commands, %0d responses checked, six configurations incl. extremes",
                 shadow.commands, shadow.responses);
        $display("seen: %0d chars sent, %0d chars read, %0d rx irqs, %0d tx irqs, %0d breaks",
                 shadow.chars_sent, shadow.chars_read, shadow.rx_irqs, shadow.tx_irqs,
                 shadow.breaks);
        if (shadow.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== serial_line_unit_4ch_core.f =====
hdl/slu4_pkg.sv
hdl/slu4_if.sv
hdl/serial_line_unit_4ch_core.sv
test/tb_serial_line_unit_4ch_core.sv
